// File: design/assert_macros.svh
// Assertion macros used by the checker file of the parameter update block.
// Depends on nothing; the clock i_clk and reset i_rst_n must exist where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define APU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define APU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define APU_ASSERT_NEXT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/apu_pkg.sv
// Package of the Adam parameter update block: beat types, pipeline lengths
// and register codes. Depends on nothing.
`default_nettype none

package apu_pkg;

    // Input beat.
    typedef struct packed {
        logic        kind;
        logic [10:0] entry_index;
        logic        stage;
        logic [47:0] operand_value;
    } t_in_item;

    // Output beat.
    typedef struct packed {
        logic [10:0] out_index;
        logic        out_stage;
        logic [31:0] new_value;
        logic        saturated;
    } t_out_item;

    // One entry of the state memory.
    typedef struct packed {
        logic [31:0] param;
        logic [47:0] mom;
        logic [63:0] vel;
    } t_entry;

    // Control that rides along the pipeline next to the data.
    typedef struct packed {
        logic        kind;
        logic        lsat;
        logic [10:0] idx;
        logic        stage;
    } t_side;

    // Data carried through the square root unit.
    typedef struct packed {
        logic [31:0] param;
        logic [47:0] mnew;
        logic [63:0] vnew;
        logic [71:0] num;
    } t_sq_tag;

    // Data carried through the divider.
    typedef struct packed {
        logic [31:0] param;
        logic [47:0] mnew;
        logic [63:0] vnew;
    } t_dv_tag;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY = 3'd3;

    localparam logic [31:0] RST_GRAD_SCALE   = 32'd0;
    localparam logic [23:0] RST_STEP_SIZE    = 24'd65536;
    localparam logic [23:0] RST_FIRST_DECAY  = 24'd15099494;
    localparam logic [23:0] RST_SECOND_DECAY = 24'd16760439;

    localparam int ROOT_W    = 32;
    localparam int QUOT_W    = 41;
    localparam int FRONT_LAT = 7;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = QUOT_W + 1;
    localparam int PIPE_LAT  = FRONT_LAT + SQRT_LAT + DIV_LAT;

endpackage

`default_nettype wire

// File: design/apu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module apu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/apu_sqrt.sv
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Depends on apu_pkg.
`default_nettype none

module apu_sqrt #(
    parameter int TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [63:0]      i_rad,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic      [31:0]      o_root,
    output logic      [TAG_W-1:0] o_tag
);

    import apu_pkg::*;

    logic [63:0]      r_x    [SQRT_LAT];
    logic [33:0]      r_rem  [SQRT_LAT];
    logic [31:0]      r_root [SQRT_LAT];
    logic [TAG_W-1:0] r_tag  [SQRT_LAT];

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_st
        logic [63:0]      w_x;
        logic [33:0]      w_rem;
        logic [31:0]      w_root;
        logic [TAG_W-1:0] w_tag;
        logic [35:0]      w_cur;
        logic [35:0]      w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_x    = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_tag  = i_tag;
        end else begin : g_next
            assign w_x    = r_x[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_tag  = r_tag[k-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign w_cur   = {w_rem, w_x[63:62]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= {w_x[61:0], 2'b00};
                r_rem[k]  <= w_ge ? 34'(w_cur - w_trial) : w_cur[33:0];
                r_root[k] <= {w_root[30:0], w_ge};
                r_tag[k]  <= w_tag;
            end
        end
    end

    assign o_root = r_root[SQRT_LAT-1];
    assign o_tag  = r_tag[SQRT_LAT-1];

endmodule

`default_nettype wire

// File: design/apu_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient capped at 2^40.
// Depends on apu_pkg.
`default_nettype none

module apu_div #(
    parameter int TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [71:0]      i_num,
    input  wire logic [40:0]      i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic      [40:0]      o_quot,
    output logic      [TAG_W-1:0] o_tag
);

    import apu_pkg::*;

    logic             r_ovf [DIV_LAT];
    logic [40:0]      r_rem [DIV_LAT];
    logic [40:0]      r_low [DIV_LAT];
    logic [40:0]      r_q   [DIV_LAT];
    logic [40:0]      r_den [DIV_LAT];
    logic [TAG_W-1:0] r_tag [DIV_LAT];

    // The quotient reaches 2^41 exactly when the top part of the numerator
    // already holds the divisor; that case is flagged and saturates at the output.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= ({10'b0, i_num[71:41]} >= i_den);
            r_rem[0] <= {10'b0, i_num[71:41]};
            r_low[0] <= i_num[40:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k < DIV_LAT; k++) begin : g_st
        logic [41:0] w_cur;
        logic        w_ge;

        assign w_cur = {r_rem[k-1], r_low[k-1][40]};
        assign w_ge  = (w_cur >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k] <= r_ovf[k-1];
                r_rem[k] <= w_ge ? 41'(w_cur - {1'b0, r_den[k-1]}) : w_cur[40:0];
                r_low[k] <= {r_low[k-1][39:0], 1'b0};
                r_q[k]   <= {r_q[k-1][39:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_quot = (r_ovf[DIV_LAT-1] || (r_q[DIV_LAT-1] > {1'b1, 40'b0}))
                  ? {1'b1, 40'b0} : r_q[DIV_LAT-1];
    assign o_tag  = r_tag[DIV_LAT-1];

endmodule

`default_nettype wire

// File: design/adam_parameter_update_unit.sv
// Top level of the Adam parameter update block: state memory, arithmetic front,
// square root and divider pipelines, write-back and output queue.
// Depends on apu_pkg, apu_ram, apu_sqrt and apu_div.
//
//   channel   direction  handshake            beat
//   input     in         i_valid / o_ready    i_data  (apu_pkg::t_in_item)
//   output    out        o_valid / i_ready    o_data  (apu_pkg::t_out_item)
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One beat is accepted per cycle while o_ready is high; each beat passes 7 front
// stages, 32 square root stages and 42 divider stages before it is queued.
// The state memory has one read and one write port; an update reads its entry
// when accepted and writes it back from the last stage. A beat whose entry is
// still in flight waits at o_ready low until that earlier beat has written back.
// The pipeline moves as a whole; it stops only when the two-entry output queue
// is full. Reset clears control state only; memory entries are undefined until
// loaded, and no clearing pass runs.
`default_nettype none

module adam_parameter_update_unit #(
    parameter int PARAM_COUNT = 2048,
    parameter int STAGE_COUNT = 2
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire apu_pkg::t_in_item              i_data,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output apu_pkg::t_out_item                  o_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [apu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [apu_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import apu_pkg::*;

    localparam int SLOTS = PARAM_COUNT * STAGE_COUNT;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Configuration registers.
    logic [31:0] r_grad_scale;
    logic [23:0] r_step_size;
    logic [23:0] r_first_decay;
    logic [23:0] r_second_decay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grad_scale   <= RST_GRAD_SCALE;
            r_step_size    <= RST_STEP_SIZE;
            r_first_decay  <= RST_FIRST_DECAY;
            r_second_decay <= RST_SECOND_DECAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRAD_SCALE:   r_grad_scale   <= i_cfg_data;
                CFG_STEP_SIZE:    r_step_size    <= i_cfg_data[23:0];
                CFG_FIRST_DECAY:  r_first_decay  <= i_cfg_data[23:0];
                CFG_SECOND_DECAY: r_second_decay <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: everything moves unless the output queue is full.
    logic [1:0] r_q_cnt;
    logic [1:0] n_q_cnt;
    logic       w_adv;
    logic       w_acc;

    assign w_adv = (r_q_cnt != 2'd2);

    // Input decode: slot address, range check and load clipping flag.
    logic [17:0]   w_slot_full;
    logic [AW-1:0] w_slot;
    logic          w_in_wr;
    logic          w_in_lsat;
    logic          w_hz;

    assign w_slot_full = 18'(i_data.entry_index) * 18'(STAGE_COUNT) + 18'(i_data.stage);
    assign w_slot      = w_slot_full[AW-1:0];
    assign w_in_wr     = (32'(i_data.entry_index) < 32'(PARAM_COUNT))
                      && (32'(i_data.stage) < 32'(STAGE_COUNT));
    assign w_in_lsat   = !((&i_data.operand_value[47:31]) || !(|i_data.operand_value[47:31]));

    // Control shift line: valid, write-back enable, slot and echo fields.
    logic          r_vld  [1:PIPE_LAT];
    logic          r_wr   [1:PIPE_LAT];
    logic [AW-1:0] r_slot [1:PIPE_LAT];
    t_side         r_sd   [1:PIPE_LAT];

    // Interlock: an in-range beat waits while any beat for the same entry is
    // between the memory read and its write-back.
    always_comb begin
        w_hz = 1'b0;
        for (int k = 1; k <= PIPE_LAT; k++) begin
            if (r_vld[k] && r_wr[k] && (r_slot[k] == w_slot)) begin
                w_hz = 1'b1;
            end
        end
    end

    assign o_ready = w_adv && !(w_in_wr && w_hz);
    assign w_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= PIPE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[1] <= w_acc;
            for (int k = 2; k <= PIPE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wr[1]       <= w_in_wr;
            r_slot[1]     <= w_slot;
            r_sd[1].kind  <= i_data.kind;
            r_sd[1].lsat  <= w_in_lsat;
            r_sd[1].idx   <= i_data.entry_index;
            r_sd[1].stage <= i_data.stage;
            for (int k = 2; k <= PIPE_LAT; k++) begin
                r_wr[k]   <= r_wr[k-1];
                r_slot[k] <= r_slot[k-1];
                r_sd[k]   <= r_sd[k-1];
            end
        end
    end

    // State memory: parameter, momentum and velocity of one slot per word.
    t_entry  w_rd_entry;
    t_entry  w_wr_entry;
    logic    w_mem_we;

    apu_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_slot[PIPE_LAT]),
        .i_wdata (w_wr_entry),
        .i_re    (w_acc),
        .i_raddr (w_slot),
        .o_rdata (w_rd_entry)
    );

    // Stage 1: read data arrives; take magnitudes and form the first partial
    // products of the gradient, the decayed momentum and the decayed velocity.
    logic [47:0] r_s1_op;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_op <= i_data.operand_value;
        end
    end

    logic [47:0] w_s1_rmag;
    logic [47:0] w_s1_mmag;
    logic [31:0] w_s1_ld;
    logic        w_s1_lsat;

    assign w_s1_rmag = r_s1_op[47] ? (48'd0 - r_s1_op) : r_s1_op;
    assign w_s1_mmag = w_rd_entry.mom[47] ? (48'd0 - w_rd_entry.mom) : w_rd_entry.mom;
    assign w_s1_lsat = !((&r_s1_op[47:31]) || !(|r_s1_op[47:31]));
    assign w_s1_ld   = w_s1_lsat ? (r_s1_op[47] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                 : r_s1_op[31:0];

    logic [55:0] r_s2_gp_lo, r_s2_gp_hi, r_s2_vp_lo, r_s2_vp_hi;
    logic [47:0] r_s2_mp_lo, r_s2_mp_hi;
    logic [31:0] r_s2_p;
    logic        r_s2_msign, r_s2_gneg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_gp_lo <= 56'(w_s1_rmag[23:0]) * 56'(r_grad_scale);
            r_s2_gp_hi <= 56'(w_s1_rmag[47:24]) * 56'(r_grad_scale);
            r_s2_mp_lo <= 48'(w_s1_mmag[23:0]) * 48'(r_first_decay);
            r_s2_mp_hi <= 48'(w_s1_mmag[47:24]) * 48'(r_first_decay);
            r_s2_vp_lo <= 56'(w_rd_entry.vel[31:0]) * 56'(r_second_decay);
            r_s2_vp_hi <= 56'(w_rd_entry.vel[63:32]) * 56'(r_second_decay);
            r_s2_p     <= (r_sd[1].kind == KIND_LOAD) ? w_s1_ld : w_rd_entry.param;
            r_s2_msign <= w_rd_entry.mom[47];
            // The scaled gradient is the negated raw gradient.
            r_s2_gneg  <= !r_s1_op[47] && (|r_s1_op);
        end
    end

    // Stage 2: sum partial products; the gradient magnitude saturates at 2^47-1.
    logic [79:0] w_s2_gprod;
    logic [71:0] w_s2_t1m;
    logic [87:0] w_s2_t1v;

    assign w_s2_gprod = 80'(r_s2_gp_lo) + {r_s2_gp_hi, 24'b0};
    assign w_s2_t1m   = 72'(r_s2_mp_lo) + {r_s2_mp_hi, 24'b0};
    assign w_s2_t1v   = 88'(r_s2_vp_lo) + {r_s2_vp_hi, 32'b0};

    logic [46:0] r_s3_gmag;
    logic [47:0] r_s3_t1m;
    logic [63:0] r_s3_t1v;
    logic [31:0] r_s3_p;
    logic        r_s3_msign, r_s3_gneg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_gmag  <= (|w_s2_gprod[79:63]) ? {47{1'b1}} : w_s2_gprod[62:16];
            r_s3_t1m   <= w_s2_t1m[71:24];
            r_s3_t1v   <= w_s2_t1v[87:24];
            r_s3_p     <= r_s2_p;
            r_s3_msign <= r_s2_msign;
            r_s3_gneg  <= r_s2_gneg;
        end
    end

    // Stage 3: partial products of (1-beta1)*g and of g squared.
    logic [24:0] w_c1;

    assign w_c1 = 25'h100_0000 - {1'b0, r_first_decay};

    logic [48:0] r_s4_tm_lo;
    logic [47:0] r_s4_tm_hi;
    logic [47:0] r_s4_s00;
    logic [46:0] r_s4_s01;
    logic [45:0] r_s4_s11;
    logic [47:0] r_s4_t1m;
    logic [63:0] r_s4_t1v;
    logic [31:0] r_s4_p;
    logic        r_s4_msign, r_s4_gneg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_tm_lo <= 49'(r_s3_gmag[23:0]) * 49'(w_c1);
            r_s4_tm_hi <= 48'(r_s3_gmag[46:24]) * 48'(w_c1);
            r_s4_s00   <= 48'(r_s3_gmag[23:0]) * 48'(r_s3_gmag[23:0]);
            r_s4_s01   <= 47'(r_s3_gmag[23:0]) * 47'(r_s3_gmag[46:24]);
            r_s4_s11   <= 46'(r_s3_gmag[46:24]) * 46'(r_s3_gmag[46:24]);
            r_s4_t1m   <= r_s3_t1m;
            r_s4_t1v   <= r_s3_t1v;
            r_s4_p     <= r_s3_p;
            r_s4_msign <= r_s3_msign;
            r_s4_gneg  <= r_s3_gneg;
        end
    end

    // Stage 4: new momentum, clamped to 48 bits signed, and the squared gradient.
    logic [71:0] w_s4_t2m;
    logic [49:0] w_s4_ma;
    logic [49:0] w_s4_mb;
    logic [49:0] w_s4_msum;
    logic [47:0] w_s4_mnew;
    logic [93:0] w_s4_sq;

    assign w_s4_t2m  = 72'(r_s4_tm_lo) + {r_s4_tm_hi, 24'b0};
    assign w_s4_ma   = r_s4_msign ? (50'd0 - 50'(r_s4_t1m)) : 50'(r_s4_t1m);
    assign w_s4_mb   = r_s4_gneg ? (50'd0 - 50'(w_s4_t2m[71:24])) : 50'(w_s4_t2m[71:24]);
    assign w_s4_msum = w_s4_ma + w_s4_mb;
    assign w_s4_mnew = ((&w_s4_msum[49:47]) || !(|w_s4_msum[49:47])) ? w_s4_msum[47:0]
                     : (w_s4_msum[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}});
    assign w_s4_sq   = 94'(r_s4_s00) + 94'({r_s4_s01, 25'b0}) + {r_s4_s11, 48'b0};

    logic [47:0] r_s5_m;
    logic [63:0] r_s5_sq;
    logic [63:0] r_s5_t1v;
    logic [31:0] r_s5_p;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_m   <= w_s4_mnew;
            r_s5_sq  <= (|w_s4_sq[93:80]) ? {64{1'b1}} : w_s4_sq[79:16];
            r_s5_t1v <= r_s4_t1v;
            r_s5_p   <= r_s4_p;
        end
    end

    // Stage 5: partial products of (1-beta2)*sq and of step_size*|m|.
    logic [24:0] w_c2;
    logic [47:0] w_s5_nmag;

    assign w_c2      = 25'h100_0000 - {1'b0, r_second_decay};
    assign w_s5_nmag = r_s5_m[47] ? (48'd0 - r_s5_m) : r_s5_m;

    logic [56:0] r_s6_vq_lo, r_s6_vq_hi;
    logic [47:0] r_s6_n_lo, r_s6_n_hi;
    logic [63:0] r_s6_t1v;
    logic [47:0] r_s6_m;
    logic [31:0] r_s6_p;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s6_vq_lo <= 57'(r_s5_sq[31:0]) * 57'(w_c2);
            r_s6_vq_hi <= 57'(r_s5_sq[63:32]) * 57'(w_c2);
            r_s6_n_lo  <= 48'(w_s5_nmag[23:0]) * 48'(r_step_size);
            r_s6_n_hi  <= 48'(w_s5_nmag[47:24]) * 48'(r_step_size);
            r_s6_t1v   <= r_s5_t1v;
            r_s6_m     <= r_s5_m;
            r_s6_p     <= r_s5_p;
        end
    end

    // Stage 6: new velocity, saturating at all ones, and the divider numerator.
    logic [88:0] w_s6_t2v;
    logic [64:0] w_s6_vsum;

    assign w_s6_t2v  = 89'(r_s6_vq_lo) + {r_s6_vq_hi, 32'b0};
    assign w_s6_vsum = 65'(r_s6_t1v) + 65'(w_s6_t2v[87:24]);

    logic [63:0] r_s7_v;
    logic [71:0] r_s7_num;
    logic [47:0] r_s7_m;
    logic [31:0] r_s7_p;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s7_v   <= w_s6_vsum[64] ? {64{1'b1}} : w_s6_vsum[63:0];
            r_s7_num <= 72'(r_s6_n_lo) + {r_s6_n_hi, 24'b0};
            r_s7_m   <= r_s6_m;
            r_s7_p   <= r_s6_p;
        end
    end

    // Square root of the velocity.
    t_sq_tag     w_sq_in;
    t_sq_tag     w_sq_out;
    logic [31:0] w_root;

    assign w_sq_in.param = r_s7_p;
    assign w_sq_in.mnew  = r_s7_m;
    assign w_sq_in.vnew  = r_s7_v;
    assign w_sq_in.num   = r_s7_num;

    apu_sqrt #(
        .TAG_W ($bits(t_sq_tag))
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (r_s7_v),
        .i_tag  (w_sq_in),
        .o_root (w_root),
        .o_tag  (w_sq_out)
    );

    // Denominator: root plus one epsilon step, moved to the Q8.24 scale.
    logic [40:0] w_den;
    t_dv_tag     w_dv_in;
    t_dv_tag     w_dv_out;
    logic [40:0] w_delta;

    assign w_den         = {({1'b0, w_root} + 33'd1), 8'b0};
    assign w_dv_in.param = w_sq_out.param;
    assign w_dv_in.mnew  = w_sq_out.mnew;
    assign w_dv_in.vnew  = w_sq_out.vnew;

    apu_div #(
        .TAG_W ($bits(t_dv_tag))
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (w_sq_out.num),
        .i_den  (w_den),
        .i_tag  (w_dv_in),
        .o_quot (w_delta),
        .o_tag  (w_dv_out)
    );

    // Last stage: apply the step, clip to 32 bits and write the entry back.
    logic [42:0] w_pext;
    logic [42:0] w_pnew;
    logic        w_usat;
    logic [31:0] w_upd;
    t_out_item   w_push_data;
    logic        w_push;
    logic        w_pop;

    assign w_pext = {{11{w_dv_out.param[31]}}, w_dv_out.param};
    assign w_pnew = w_dv_out.mnew[47] ? (w_pext + {2'b00, w_delta})
                                      : (w_pext - {2'b00, w_delta});
    assign w_usat = !((&w_pnew[42:31]) || !(|w_pnew[42:31]));
    assign w_upd  = w_usat ? (w_pnew[42] ? 32'h8000_0000 : 32'h7FFF_FFFF) : w_pnew[31:0];

    always_comb begin
        w_push_data.out_index = r_sd[PIPE_LAT].idx;
        w_push_data.out_stage = r_sd[PIPE_LAT].stage;
        w_wr_entry            = '0;
        if (!r_wr[PIPE_LAT]) begin
            w_push_data.new_value = '0;
            w_push_data.saturated = 1'b0;
        end else if (r_sd[PIPE_LAT].kind == KIND_LOAD) begin
            w_push_data.new_value = w_dv_out.param;
            w_push_data.saturated = r_sd[PIPE_LAT].lsat;
            w_wr_entry.param      = w_dv_out.param;
        end else begin
            w_push_data.new_value = w_upd;
            w_push_data.saturated = w_usat;
            w_wr_entry.param      = w_upd;
            w_wr_entry.mom        = w_dv_out.mnew;
            w_wr_entry.vel        = w_dv_out.vnew;
        end
    end

    assign w_push   = w_adv && r_vld[PIPE_LAT];
    assign w_mem_we = w_push && r_wr[PIPE_LAT];

    // Two-entry output queue; the pipeline keeps running while one result waits.
    t_out_item r_q [2];

    assign o_valid = (r_q_cnt != 2'd0);
    assign o_data  = r_q[0];
    assign w_pop   = o_valid && i_ready;
    assign n_q_cnt = r_q_cnt + 2'(w_push) - 2'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else begin
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_q[0] <= (r_q_cnt == 2'd2) ? r_q[1] : w_push_data;
        end else if (w_push && (r_q_cnt == 2'd0)) begin
            r_q[0] <= w_push_data;
        end
        if (w_push && !w_pop && (r_q_cnt == 2'd1)) begin
            r_q[1] <= w_push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/apu_checker.sv
// Port-level checker for the Adam parameter update block and its bind.
// Depends on apu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module apu_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_ready,
    input wire apu_pkg::t_out_item i_out_data
);

    // Beats accepted but not yet delivered.
    logic [7:0] r_pend;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = i_valid && i_in_ready;
    assign w_out_beat = i_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 8'd0;
        end else begin
            r_pend <= r_pend + 8'(w_in_beat) - 8'(w_out_beat);
        end
    end

    `APU_ASSERT_NEXT_RST(a_rst_clears_out, !i_rst_n, !i_out_valid, "result valid after reset")
    `APU_ASSERT_SAME(a_no_extra_result, i_out_valid, r_pend != 8'd0, "result without input beat")
    `APU_ASSERT_NEXT(a_out_valid_holds, i_out_valid && !i_ready, i_out_valid, "result dropped")
    `APU_ASSERT_NEXT(a_out_data_holds, i_out_valid && !i_ready, $stable(i_out_data), "result changed")

endmodule

bind adam_parameter_update_unit apu_checker u_apu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_ready     (i_ready),
    .i_out_data  (o_data)
);

`default_nettype wire
